// ===== sv/mexp_pkg.sv =====
// Package for the modular exponentiation unit: field widths and the
// configuration register indexes. No dependencies.
package mexp_pkg;

  // Width of every external field (base, result, registers).
  localparam int unsigned FIELD_WIDTH = 32;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'b1;

  // Register values after reset.
  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd1;
  localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd1;

endpackage

// ===== sv/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: base ^ exponent mod modulus by right-to-left
// square and multiply over a bit-serial shift-and-add modular multiplier.
// Depends on mexp_pkg.
//
//   Channel  | Direction | Handshake             | Payload
//   s_axis   | in        | tvalid / tready       | tdata: base_value [31:0]
//   m_axis   | out       | tvalid / tready       | tdata: power_residue [31:0]
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. An item is loaded, its base is reduced modulo the
// modulus one bit at a time, then the modular multiplies run in turn:
// one square per exponent bit below the top set bit and one multiply per set
// bit. The multiplier consumes one bit of its second operand per cycle.
// Reset (rst_ni low, asynchronous) sets modulus and exponent to 1.
// A waiting result sits in the output register; the next item is taken
// while it waits, and a finished result holds until that register is free.
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [mexp_pkg::FIELD_WIDTH-1:0]       cfg_data_i,
  // Input stream.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [mexp_pkg::FIELD_WIDTH-1:0]       s_axis_tdata_i,  // [31:0] base_value
  // Output stream.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [mexp_pkg::FIELD_WIDTH-1:0]       m_axis_tdata_o   // [31:0] power_residue
);
  import mexp_pkg::*;

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_FINISH
  } state_e;

  // (x + y) mod m for x < m and y < m.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    logic [W:0] diff;
    sum  = {1'b0, x} + {1'b0, y};
    diff = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      return diff[W-1:0];
    end
    return sum[W-1:0];
  endfunction

  // Control and configuration registers.
  state_e               state_q, state_d;
  logic [FIELD_WIDTH-1:0] modulus_reg_q, modulus_reg_d;
  logic [FIELD_WIDTH-1:0] exponent_reg_q, exponent_reg_d;
  logic                 out_valid_q, out_valid_d;
  logic [FIELD_WIDTH-1:0] out_data_q, out_data_d;

  // Datapath registers.
  logic [W-1:0]     mod_q, mod_d;
  logic [W-1:0]     exp_q, exp_d;
  logic [W-1:0]     base_q, base_d;
  logic [W-1:0]     sq_q, sq_d;
  logic [W-1:0]     res_q, res_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     mul_a_q, mul_a_d;
  logic [W-1:0]     mul_b_q, mul_b_d;
  logic             mul_to_sq_q, mul_to_sq_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Width adaptation between the 32-bit fields and the operand width.
  logic [W+FIELD_WIDTH-1:0] base_ext, mod_ext, exp_ext, res_ext;
  logic [W-1:0]             base_w, mod_w, exp_w;

  assign base_ext = {{W{1'b0}}, s_axis_tdata_i};
  assign mod_ext  = {{W{1'b0}}, modulus_reg_q};
  assign exp_ext  = {{W{1'b0}}, exponent_reg_q};
  assign base_w   = base_ext[W-1:0];
  assign mod_w    = mod_ext[W-1:0];
  assign exp_w    = exp_ext[W-1:0];
  assign res_ext  = {{FIELD_WIDTH{1'b0}}, res_q};

  // One restoring step of the base reduction.
  logic [W:0] red_shift;
  logic [W:0] red_diff;
  logic [W-1:0] red_next;

  assign red_shift = {acc_q, base_q[W-1]};
  assign red_diff  = red_shift - {1'b0, mod_q};
  assign red_next  = (red_shift >= {1'b0, mod_q}) ? red_diff[W-1:0] : red_shift[W-1:0];

  // One shift-and-add step of the modular multiplier.
  logic [W-1:0] mul_acc_next;
  logic [W-1:0] mul_dbl_next;

  assign mul_acc_next = mul_b_q[0] ? add_mod(acc_q, mul_a_q, mod_q) : acc_q;
  assign mul_dbl_next = add_mod(mul_a_q, mul_a_q, mod_q);

  logic in_accept;
  logic out_accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_accept      = out_valid_q && m_axis_tready_i;

  // Next-state and datapath logic.
  always_comb begin
    state_d        = state_q;
    modulus_reg_d  = modulus_reg_q;
    exponent_reg_d = exponent_reg_q;
    out_valid_d    = out_valid_q && !out_accept;
    out_data_d     = out_data_q;
    mod_d          = mod_q;
    exp_d          = exp_q;
    base_d         = base_q;
    sq_d           = sq_q;
    res_d          = res_q;
    acc_d          = acc_q;
    mul_a_d        = mul_a_q;
    mul_b_d        = mul_b_q;
    mul_to_sq_d    = mul_to_sq_q;
    cnt_d          = cnt_q;

    // Register writes.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODULUS:  modulus_reg_d  = cfg_data_i;
        REG_EXPONENT: exponent_reg_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mod_d  = mod_w;
          exp_d  = exp_w;
          base_d = base_w;
          acc_d  = '0;
          cnt_d  = CNT_LAST;
          res_d  = (mod_w == W'(1)) ? '0 : W'(1);
          if (exp_w == '0) begin
            // A zero exponent gives one, whatever the modulus.
            res_d   = W'(1);
            state_d = ST_FINISH;
          end else if (mod_w == '0) begin
            res_d   = '0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        acc_d  = red_next;
        base_d = {base_q[W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          sq_d    = red_next;
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        // A set low bit multiplies the result first, then the square follows.
        acc_d   = '0;
        cnt_d   = CNT_LAST;
        mul_a_d = sq_q;
        if (exp_q == '0) begin
          state_d = ST_FINISH;
        end else if (exp_q[0]) begin
          mul_b_d     = res_q;
          mul_to_sq_d = 1'b0;
          state_d     = ST_MUL;
        end else begin
          mul_b_d     = sq_q;
          mul_to_sq_d = 1'b1;
          state_d     = ST_MUL;
        end
      end

      ST_MUL: begin
        acc_d   = mul_acc_next;
        mul_a_d = mul_dbl_next;
        mul_b_d = {1'b0, mul_b_q[W-1:1]};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (mul_to_sq_q) begin
            sq_d  = mul_acc_next;
            exp_d = {1'b0, exp_q[W-1:1]};
          end else begin
            res_d = mul_acc_next;
            exp_d = {exp_q[W-1:1], 1'b0};
          end
          state_d = ST_STEP;
        end
      end

      ST_FINISH: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_ext[FIELD_WIDTH-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, configuration and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      modulus_reg_q  <= MODULUS_RESET;
      exponent_reg_q <= EXPONENT_RESET;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      state_q        <= state_d;
      modulus_reg_q  <= modulus_reg_d;
      exponent_reg_q <= exponent_reg_d;
      out_valid_q    <= out_valid_d;
      out_data_q     <= out_data_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mod_q       <= mod_d;
    exp_q       <= exp_d;
    base_q      <= base_d;
    sq_q        <= sq_d;
    res_q       <= res_d;
    acc_q       <= acc_d;
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    mul_to_sq_q <= mul_to_sq_d;
    cnt_q       <= cnt_d;
  end

endmodule

// ===== sv/mexp_checker.sv =====
// Port-level checks for the modular exponentiation unit, bound to its top
// level. Depends on mexp_pkg and modular_exponentiation_unit.
module mexp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid_i,
  input logic                                 s_axis_tready_o,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [mexp_pkg::FIELD_WIDTH-1:0]     m_axis_tdata_o
);
  import mexp_pkg::*;

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item changed or dropped while stalled");

  // The unit works on one item at a time: it closes its input after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in progress");

  // A new result appears only as the unit returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result presented while the unit is still busy");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
